[hdl/pkst_pkg.sv]
// ----------------------------------------------------------------------------
// pkst_pkg
// shared types and constants of the pair key signature table
// ----------------------------------------------------------------------------
package pkst_pkg;

  localparam int unsigned ENTRIES_DEF     = 64;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned HDL_W    = 16;
  localparam int unsigned STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW    = 3'd0,
    ST_ACTIVE = 3'd1,
    ST_REACT  = 3'd2,
    ST_ERASED = 3'd3,
    ST_MISS   = 3'd4,
    ST_FULL   = 3'd5
  } pkst_status_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_first;
    logic [KEY_W-1:0] key_second;
    logic             swap_key;
    logic [HDL_W-1:0] elem_handle;
  } pkst_req_t;

  typedef struct packed {
    logic [HDL_W-1:0]    result_handle;
    logic [STATUS_W-1:0] status;
  } pkst_res_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             cmp;
    logic             upd;
    logic [CMD_W-1:0] cmd;
    logic             hit_any;
  } pkst_ctrl_t;

  // hit information passed from cell to cell
  typedef struct packed {
    logic hit;
    logic active;
  } pkst_link_t;

endpackage

[hdl/pkst_cell.sv]
// ----------------------------------------------------------------------------
// pkst_cell
// one table slot: stored key pair, handle, active and used marks, key compare
// ----------------------------------------------------------------------------
module pkst_cell
  import pkst_pkg::*;
#(
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pkst_ctrl_t             ctrl_i,
  input  logic [ID_BITS-1:0]     key1_i,
  input  logic [ID_BITS-1:0]     key2_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  input  logic                   prev_used_i,
  input  pkst_link_t             link_i,
  input  logic [HANDLE_BITS-1:0] link_handle_i,
  output logic                   used_o,
  output pkst_link_t             link_o,
  output logic [HANDLE_BITS-1:0] link_handle_o
);

  logic [ID_BITS-1:0]     key1_q;
  logic [ID_BITS-1:0]     key2_q;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   active_q, active_d;
  logic                   used_q, used_d;
  logic                   match_q, match_d;
  logic                   alloc;
  logic                   key_we;
  logic                   handle_we;

  // first never-used slot
  assign alloc = !used_q && prev_used_i;

  always_comb begin
    match_d   = match_q;
    active_d  = active_q;
    used_d    = used_q;
    key_we    = 1'b0;
    handle_we = 1'b0;
    if (ctrl_i.cmp) begin
      match_d = used_q && (key1_q == key1_i) && (key2_q == key2_i);
    end
    if (ctrl_i.upd) begin
      if (ctrl_i.cmd == CMD_INSERT) begin
        if (match_q && !active_q) begin
          active_d  = 1'b1;
          handle_we = 1'b1;
        end else if (!ctrl_i.hit_any && alloc) begin
          active_d  = 1'b1;
          used_d    = 1'b1;
          key_we    = 1'b1;
          handle_we = 1'b1;
        end
      end else if (ctrl_i.cmd == CMD_ERASE) begin
        if (match_q) begin
          active_d = 1'b0;
        end
      end
    end
    handle_d = handle_we ? handle_i : handle_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q  <= 1'b0;
      active_q <= 1'b0;
      used_q   <= 1'b0;
    end else begin
      match_q  <= match_d;
      active_q <= active_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key1_q <= key1_i;
      key2_q <= key2_i;
    end
    handle_q <= handle_d;
  end

  assign used_o        = used_q;
  assign link_o.hit    = match_q ? 1'b1 : link_i.hit;
  assign link_o.active = match_q ? active_q : link_i.active;
  assign link_handle_o = match_q ? handle_q : link_handle_i;

endmodule

[hdl/pair_key_signature_table.sv]
// ----------------------------------------------------------------------------
// pair_key_signature_table
// associative table keyed by a pair of class identifiers
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command passes
// through the accepting edge, which registers the request, the compare state,
// which registers the key compare in every cell, and the update state, which
// resolves the hit along the row of cells, writes the slot and registers the
// answer. done_o marks the result for exactly one cycle right after that, and
// the receiver cannot hold it off; busy is high in the compare and update
// states, so a new command can be accepted in the cycle its predecessor's
// result shows. The length of the hit chain through all ENTRIES cells sets
// the update path. There is no clearing pass after reset; the table is usable
// at once.
module pair_key_signature_table
  import pkst_pkg::*;
#(
  parameter int unsigned ENTRIES     = ENTRIES_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pkst_req_t req_i,
  output logic      done_o,
  output pkst_res_t res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CMD_W-1:0]       cmd_q;
  logic [ID_BITS-1:0]     key1_q, key2_q;
  logic [HANDLE_BITS-1:0] hdl_q;
  logic                   done_q, done_d;
  pkst_res_t              res_q, res_d;
  logic                   accept;
  logic [ID_BITS-1:0]     key_a, key_b;

  pkst_ctrl_t             ctrl;
  pkst_link_t             link_w [ENTRIES+1];
  logic [HANDLE_BITS-1:0] lhdl_w [ENTRIES+1];
  logic [ENTRIES:0]       used_w;
  logic                   full;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign key_a  = ID_BITS'(req_i.key_first);
  assign key_b  = ID_BITS'(req_i.key_second);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.cmd;
      key1_q <= req_i.swap_key ? key_b : key_a;
      key2_q <= req_i.swap_key ? key_a : key_b;
      hdl_q  <= HANDLE_BITS'(req_i.elem_handle);
    end
    res_q <= res_d;
  end

  // cell row
  assign ctrl.cmp     = (state_q == S_CMP);
  assign ctrl.upd     = (state_q == S_UPD);
  assign ctrl.cmd     = cmd_q;
  assign ctrl.hit_any = link_w[ENTRIES].hit;

  assign link_w[0] = '0;
  assign lhdl_w[0] = '0;
  assign used_w[0] = 1'b1;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pkst_cell #(
      .ID_BITS     (ID_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key1_i        (key1_q),
      .key2_i        (key2_q),
      .handle_i      (hdl_q),
      .prev_used_i   (used_w[i]),
      .link_i        (link_w[i]),
      .link_handle_i (lhdl_w[i]),
      .used_o        (used_w[i+1]),
      .link_o        (link_w[i+1]),
      .link_handle_o (lhdl_w[i+1])
    );
  end

  assign full = used_w[ENTRIES];

  always_comb begin
    done_d              = ctrl.upd;
    res_d.result_handle = '0;
    res_d.status        = ST_MISS;
    case (cmd_q)
      CMD_INSERT: begin
        if (link_w[ENTRIES].hit && link_w[ENTRIES].active) begin
          res_d.result_handle = HDL_W'(lhdl_w[ENTRIES]);
          res_d.status        = ST_ACTIVE;
        end else if (link_w[ENTRIES].hit) begin
          res_d.result_handle = HDL_W'(hdl_q);
          res_d.status        = ST_REACT;
        end else if (!full) begin
          res_d.result_handle = HDL_W'(hdl_q);
          res_d.status        = ST_NEW;
        end else begin
          res_d.status = ST_FULL;
        end
      end
      CMD_ERASE: begin
        if (link_w[ENTRIES].hit) res_d.status = ST_ERASED;
      end
      CMD_LOOKUP: begin
        if (link_w[ENTRIES].hit && link_w[ENTRIES].active) begin
          res_d.result_handle = HDL_W'(lhdl_w[ENTRIES]);
          res_d.status        = ST_ACTIVE;
        end
      end
      default: res_d.status = ST_MISS;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CMP))
    else $error("accepted transfer did not start compare");

  a_cmp_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |=> (state_q == S_UPD))
    else $error("compare not followed by update");

  a_upd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (done_o && !busy))
    else $error("update not followed by result transfer");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_UPD))
    else $error("result strobe without update");

  a_used_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, used_w} + {{(ENTRIES+1){1'b0}}, 1'b1}))
    else $error("used slots are not a prefix");
`endif

endmodule

[tb/pair_key_signature_table_tb.sv]
// ----------------------------------------------------------------------------
// pair_key_signature_table_tb
// self-checking testbench of the pair key signature table
// ----------------------------------------------------------------------------
// A directed run covers the empty table, swapped keys, erase of active and
// inactive slots, reactivation, lookup of erased keys, the unused command
// code and the extreme key and handle values. A random run then draws keys
// from a pool that grows over time, so that hits, erases and reactivations
// are common and the table fills up and answers table full. Every accepted
// command is predicted by a scoreboard that keeps its own copy of the table.
// Every result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pair_key_signature_table_tb
  import pkst_pkg::*;
;

  localparam int unsigned SLOTS       = ENTRIES_DEF;
  localparam int unsigned POOL_SIZE   = 80;
  localparam int unsigned RAND_ITEMS  = 500;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class pair_table_checker;
    logic [KEY_W-1:0] slot_first [SLOTS];
    logic [KEY_W-1:0] slot_second[SLOTS];
    logic [HDL_W-1:0] slot_handle[SLOTS];
    bit               slot_active[SLOTS];
    int unsigned      slots_filled;
    pkst_res_t        pending_answers[$];
    int unsigned      errors;

    function new();
      slots_filled = 0;
      errors       = 0;
      foreach (slot_active[i]) slot_active[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction

    // works out the answer of one accepted command and updates the table
    function void note_request(pkst_req_t r);
      logic [KEY_W-1:0] k1;
      logic [KEY_W-1:0] k2;
      int               hit_slot;
      pkst_res_t        ans;
      k1       = r.swap_key ? r.key_second : r.key_first;
      k2       = r.swap_key ? r.key_first : r.key_second;
      hit_slot = -1;
      for (int i = 0; i < int'(slots_filled); i++) begin
        if (hit_slot < 0 && slot_first[i] == k1 && slot_second[i] == k2) hit_slot = i;
      end
      ans.result_handle = '0;
      ans.status        = ST_MISS;
      case (r.cmd)
        CMD_INSERT: begin
          if (hit_slot >= 0) begin
            if (slot_active[hit_slot]) begin
              ans.result_handle = slot_handle[hit_slot];
              ans.status        = ST_ACTIVE;
            end else begin
              slot_active[hit_slot] = 1'b1;
              slot_handle[hit_slot] = r.elem_handle;
              ans.result_handle     = r.elem_handle;
              ans.status            = ST_REACT;
            end
          end else if (slots_filled < SLOTS) begin
            slot_first[slots_filled]  = k1;
            slot_second[slots_filled] = k2;
            slot_handle[slots_filled] = r.elem_handle;
            slot_active[slots_filled] = 1'b1;
            slots_filled++;
            ans.result_handle = r.elem_handle;
            ans.status        = ST_NEW;
          end else begin
            ans.status = ST_FULL;
          end
        end
        CMD_ERASE: begin
          if (hit_slot >= 0) begin
            slot_active[hit_slot] = 1'b0;
            ans.status            = ST_ERASED;
          end
        end
        CMD_LOOKUP: begin
          if (hit_slot >= 0 && slot_active[hit_slot]) begin
            ans.result_handle = slot_handle[hit_slot];
            ans.status        = ST_ACTIVE;
          end
        end
        default: ;
      endcase
      pending_answers = {pending_answers, ans};
    endfunction

    task report(string what, logic [HDL_W-1:0] got, logic [HDL_W-1:0] want);
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
      errors++;
    endtask

    task check_result(pkst_res_t got);
      pkst_res_t want;
      if (pending_answers.size() == 0) begin
        report("unexpected result", got.result_handle, '0);
      end else begin
        want = pending_answers.pop_front();
        if (got.result_handle !== want.result_handle)
          report("result_handle", got.result_handle, want.result_handle);
        if (got.status !== want.status)
          report("status", HDL_W'(got.status), HDL_W'(want.status));
      end
    endtask
  endclass

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  pkst_req_t cmd_req = '0;
  logic      done_o;
  pkst_res_t res_o;

  pair_table_checker sb;
  int unsigned       cycles = 0;
  logic [KEY_W-1:0]  pool_a[POOL_SIZE];
  logic [KEY_W-1:0]  pool_b[POOL_SIZE];

  pair_key_signature_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (cmd_req),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #4 clk_i = ~clk_i;

  // result check first: a new command may be taken while the last answer shows
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (start && !busy) sb.note_request(cmd_req);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pair_key_signature_table] ERROR");
      $finish;
    end
  end

  // holds start high until the transfer happens
  task automatic send_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb,
                          logic sw, logic [HDL_W-1:0] h, int unsigned gap);
    pkst_req_t r;
    r.cmd         = c;
    r.key_first   = ka;
    r.key_second  = kb;
    r.swap_key    = sw;
    r.elem_handle = h;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    cmd_req <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  initial begin
    int unsigned      sel;
    int unsigned      idx;
    int unsigned      top;
    bit               burst;
    bit               sw;
    bit               keep_order;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] e1;
    logic [KEY_W-1:0] e2;

    sb = new();
    foreach (pool_a[i]) begin
      pool_a[i] = KEY_W'($urandom);
      pool_b[i] = KEY_W'($urandom);
    end
    pool_a[0] = '1;
    pool_b[0] = '0;
    pool_a[1] = '0;
    pool_b[1] = '1;
    pool_a[2] = 16'h5a5a;
    pool_b[2] = 16'h5a5a;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_cmd(CMD_LOOKUP, '0, '0, 1'b0, 16'h1111, 0);
    send_cmd(CMD_ERASE, '1, '1, 1'b0, 16'h2222, 3);
    send_cmd(CMD_INSERT, '0, '0, 1'b0, '1, 0);
    send_cmd(CMD_INSERT, '1, '1, 1'b1, '0, 0);
    send_cmd(CMD_INSERT, 16'h0001, 16'h0002, 1'b0, 16'h1234, 1);
    send_cmd(CMD_INSERT, 16'h0002, 16'h0001, 1'b1, 16'h5555, 0);
    send_cmd(CMD_LOOKUP, 16'h0002, 16'h0001, 1'b1, 16'h0000, 2);
    send_cmd(CMD_LOOKUP, 16'h0002, 16'h0001, 1'b0, 16'h0000, 0);
    send_cmd(CMD_ERASE, 16'h0001, 16'h0002, 1'b0, 16'hffff, 0);
    send_cmd(CMD_ERASE, 16'h0002, 16'h0001, 1'b1, 16'h0000, 5);
    send_cmd(CMD_LOOKUP, 16'h0001, 16'h0002, 1'b0, 16'h0000, 0);
    send_cmd(CMD_INSERT, 16'h0002, 16'h0001, 1'b1, 16'haaaa, 0);
    send_cmd(CMD_LOOKUP, 16'h0001, 16'h0002, 1'b0, 16'h0000, 13);
    send_cmd(CMD_UNUSED, '0, '0, 1'b0, '1, 0);
    send_cmd(CMD_UNUSED, '1, '1, 1'b1, '0, 0);
    send_cmd(CMD_INSERT, '1, '0, 1'b0, 16'h8000, 0);
    send_cmd(CMD_ERASE, '0, '1, 1'b1, 16'h0000, 0);
    send_cmd(CMD_INSERT, '0, '1, 1'b1, 16'h7fff, 0);
    send_cmd(CMD_INSERT, '0, '1, 1'b0, 16'h0001, 4);
    send_cmd(CMD_INSERT, 16'habcd, 16'habcd, 1'b1, 16'hc3c3, 0);
    send_cmd(CMD_LOOKUP, 16'habcd, 16'habcd, 1'b0, 16'h0000, 0);
    send_cmd(CMD_LOOKUP, '0, '0, 1'b1, 16'h0000, 0);

    // random part, key pool widens so the table fills part way through
    burst = 1'b0;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 45)      c = CMD_INSERT;
      else if (sel < 65) c = CMD_ERASE;
      else if (sel < 95) c = CMD_LOOKUP;
      else               c = CMD_UNUSED;
      sw = $urandom_range(0, 1);
      if ($urandom_range(0, 99) < 85) begin
        top        = 20 + n / 6;
        if (top > POOL_SIZE - 1) top = POOL_SIZE - 1;
        idx        = $urandom_range(0, top);
        keep_order = ($urandom_range(0, 3) != 0);
        e1         = keep_order ? pool_a[idx] : pool_b[idx];
        e2         = keep_order ? pool_b[idx] : pool_a[idx];
        if (sw) send_cmd(c, e2, e1, sw, HDL_W'($urandom), draw_gap(burst));
        else    send_cmd(c, e1, e2, sw, HDL_W'($urandom), draw_gap(burst));
      end else begin
        send_cmd(c, KEY_W'($urandom), KEY_W'($urandom), sw, HDL_W'($urandom),
                 draw_gap(burst));
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[pair_key_signature_table] OK");
    end else begin
      $display("[pair_key_signature_table] ERROR");
    end
    $finish;
  end

endmodule
